### hw/rtl/fmrv_pkg.sv
// ----------------------------------------------------------------------------
// fmrv_pkg
// Shared sizes, opcodes, status codes, state type and the control bundle
// for the queue with remove-by-value.
// ----------------------------------------------------------------------------
package fmrv_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int DATA_W      = 32;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int ENTRY_W     = 5;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_UPDATE = 1'b1
  } state_t;

  // Control shared by every cell of the chain.
  typedef struct packed {
    logic              capture;    // request accepted: latch compare result
    logic [DATA_W-1:0] cmp_value;  // value of the incoming request
    logic              do_pop;     // every cell takes its neighbor's data
    logic              do_remove;  // cells at or behind the first hit shift
    logic [DATA_W-1:0] load_value; // value written by a push
  } cell_ctl_t;

endpackage

### hw/rtl/fmrv_ifs.sv
// ----------------------------------------------------------------------------
// fmrv request / response channels
// Valid/ready channels carrying the request and the response payload.
// ----------------------------------------------------------------------------
interface fmrv_req_if
  import fmrv_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface fmrv_rsp_if
  import fmrv_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] removed_value;
  logic [ENTRY_W-1:0]       entry_count;

  modport source (output valid, output status, output removed_value,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input removed_value,
                  input entry_count, output ready);
endinterface

### hw/rtl/fmrv_cell.sv
// ----------------------------------------------------------------------------
// fmrv_cell
// One queue slot: holds a word, compares it against the request value and
// takes the word of the cell behind it when the gap closes.
// ----------------------------------------------------------------------------
module fmrv_cell
  import fmrv_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic              occupied,   // slot index below the fill count
  input  logic              load,       // push lands in this slot
  input  logic [DATA_W-1:0] data_behind,
  input  logic              hit_in,     // a slot nearer the head matched
  output logic              hit_out,
  output logic [DATA_W-1:0] data
);

  logic match;
  logic match_eff;
  logic shift;

  assign match_eff = match & occupied;
  assign hit_out   = hit_in | match_eff;
  assign shift     = ctl.do_pop | (ctl.do_remove & hit_out);

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      match <= (data == ctl.cmp_value);
    end
    if (load) begin
      data <= ctl.load_value;
    end else if (shift) begin
      data <= data_behind;
    end
  end

endmodule

### hw/rtl/fifo_with_remove_by_value_core.sv
// ----------------------------------------------------------------------------
// fifo_with_remove_by_value_core
// Bounded FIFO with pop and delete-first-match, built as a row of slots.
// Response: registered in the update state after an accept; one request at
//   a time, taken in idle with no response stalled. Slots compare in the
//   accept cycle; the hit chain and the slot shift run in the following cycle.
// Reset: rst (synchronous) empties the queue and drops a pending response;
//   slot contents are not cleared.
// ----------------------------------------------------------------------------
module fifo_with_remove_by_value_core
  import fmrv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  fmrv_req_if.sink    req,
  fmrv_rsp_if.source  rsp
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [OP_W-1:0]   op_q;
  logic [DATA_W-1:0] value_q;
  logic              accept;
  logic              not_empty;
  logic              is_full;
  logic              found;
  logic              push_ok;
  cell_ctl_t         ctl;

  logic [DATA_W-1:0] data [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0] hit;

  status_t           status_next;
  logic [DATA_W-1:0] removed_next;
  logic [CNT_W+ENTRY_W-1:0] count_wide;

  assign req.ready = (state == S_IDLE) && (!rsp.valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign not_empty = (count != '0);
  assign is_full   = (count == CNT_W'(QUEUE_DEPTH));
  assign found     = hit[QUEUE_DEPTH];
  assign push_ok   = (state == S_UPDATE) && (op_q == OP_PUSH) && !is_full;

  always_comb begin
    ctl.capture    = accept;
    ctl.cmp_value  = req.value;
    ctl.do_pop     = (state == S_UPDATE) && (op_q == OP_POP) && not_empty;
    ctl.do_remove  = (state == S_UPDATE) && (op_q == OP_REMOVE) && not_empty;
    ctl.load_value = value_q;
  end

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] behind;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign behind = '0;
    end else begin : g_mid
      assign behind = data[i+1];
    end
    fmrv_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (CNT_W'(i) < count),
      .load        (push_ok && (count == CNT_W'(i))),
      .data_behind (behind),
      .hit_in      (hit[i]),
      .hit_out     (hit[i+1]),
      .data        (data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= req.opcode;
      value_q <= req.value;
    end
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    status_next  = STAT_OK;
    removed_next = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_next = S_IDLE;
        case (op_q)
          OP_PUSH: begin
            if (is_full) begin
              status_next = STAT_FULL;
            end else begin
              count_next = count + 1'b1;
            end
          end
          OP_POP: begin
            if (!not_empty) begin
              status_next = STAT_EMPTY;
            end else begin
              removed_next = data[0];
              count_next   = count - 1'b1;
            end
          end
          OP_REMOVE: begin
            if (!not_empty) begin
              status_next = STAT_EMPTY;
            end else if (!found) begin
              status_next = STAT_NOT_FOUND;
            end else begin
              removed_next = value_q;  // the hit equals the searched value
              count_next   = count - 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign count_wide = {{ENTRY_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_UPDATE) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_UPDATE) begin
      rsp.status        <= status_next;
      rsp.removed_value <= removed_next;
      rsp.entry_count   <= count_wide[ENTRY_W-1:0];
    end
  end

endmodule

### hw/rtl/fmrv_checker.sv
// ----------------------------------------------------------------------------
// fmrv_checker
// Port-level checks on the queue core, attached by bind.
// ----------------------------------------------------------------------------
module fmrv_checker
  import fmrv_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] rsp_status,
  input logic [ENTRY_W-1:0]  rsp_entry_count
);

  localparam logic [ENTRY_W-1:0] FULL_COUNT = ENTRY_W'(QUEUE_DEPTH);

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while another is in flight");

  a_rsp_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |-> ##2 rsp_valid)
    else $error("response missing two cycles after request");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status == STAT_EMPTY) |-> (rsp_entry_count == '0))
    else $error("empty status with nonzero count");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status == STAT_FULL) |-> (rsp_entry_count == FULL_COUNT))
    else $error("full status with wrong count");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("response dropped before it was taken");

endmodule

bind fifo_with_remove_by_value_core fmrv_checker u_fmrv_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_entry_count (rsp.entry_count)
);
